FILE: rtl/core/kct_pkg.sv
// Package for the key and count table: request and result item types,
// mode and status codes, and the controller state encoding.
// Used by kct_store and key_count_table; depends on nothing else.
package kct_pkg;

  localparam int unsigned TableDepthDefault = 16;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_QUERY  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_DONE   = 2'd0,
    STATUS_BAD    = 2'd1,
    STATUS_FULL   = 2'd2,
    STATUS_ABSENT = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EXEC,
    ST_MOVE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] item_key;
    logic [7:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] quantity_now;
    logic [4:0] entries_used;
  } out_item_t;

  typedef struct packed {
    logic [7:0] key;
    logic [7:0] qty;
  } entry_t;

endpackage

FILE: rtl/core/kct_store.sv
// Entry store of the key and count table: one synchronous memory of key and
// count pairs with one write port and one registered read port.
// Depends on kct_pkg for the entry type.
module kct_store #(
  parameter int unsigned TableDepth = kct_pkg::TableDepthDefault,
  localparam int unsigned AddrW = (TableDepth > 1) ? $clog2(TableDepth) : 1
) (
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  logic [AddrW-1:0]    rd_addr_i,
  output kct_pkg::entry_t     rd_data_o,
  input  logic                wr_en_i,
  input  logic [AddrW-1:0]    wr_addr_i,
  input  kct_pkg::entry_t     wr_data_i
);

  kct_pkg::entry_t mem [TableDepth];
  kct_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/core/key_count_table.sv
// Key and count table: add, remove and query requests on packed key/count pairs.
// Requests pass through the states search, execute, move (only when a remove empties an
// entry) and done; the linear search reads one entry per cycle.
// The next item is accepted only once the result is registered, later while the output
// is stalled.
// Reset clears the entry count and reserved key; the memory is not cleared.
module key_count_table #(
  parameter int unsigned TableDepth = kct_pkg::TableDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  kct_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output kct_pkg::out_item_t  out_item_o
);

  localparam int unsigned AddrW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned UsedW = $clog2(TableDepth + 1);

  kct_pkg::state_e    state_q, state_d;
  kct_pkg::in_item_t  req_q, req_d;
  kct_pkg::out_item_t res_q, res_d;
  kct_pkg::out_item_t out_item_q, out_item_d;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         reserved_q, reserved_d;
  logic [UsedW-1:0]   used_q, used_d;
  logic [UsedW-1:0]   idx_q, idx_d;
  logic               rvalid_q, rvalid_d;
  logic [AddrW-1:0]   ridx_q, ridx_d;
  logic               found_q, found_d;
  logic [AddrW-1:0]   pos_q, pos_d;
  logic [7:0]         qty_q, qty_d;

  logic               rd_en;
  logic [AddrW-1:0]   rd_addr;
  kct_pkg::entry_t    rd_data;
  logic               wr_en;
  logic [AddrW-1:0]   wr_addr;
  kct_pkg::entry_t    wr_data;

  logic [31:0]        used_ext;
  logic [7:0]         qty_sum;
  logic [7:0]         qty_diff;
  logic [7:0]         qty_seen;
  logic [UsedW-1:0]   used_last;

  kct_store #(
    .TableDepth(TableDepth)
  ) u_store (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != kct_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign qty_sum   = 8'(qty_q + req_q.amount);
  assign qty_diff  = 8'(qty_q - req_q.amount);
  assign qty_seen  = found_q ? qty_q : 8'd0;
  assign used_last = UsedW'(used_q - UsedW'(1));

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    res_d       = res_q;
    out_item_d  = out_item_q;
    out_valid_d = out_valid_q;
    reserved_d  = reserved_q;
    used_d      = used_q;
    idx_d       = idx_q;
    rvalid_d    = rvalid_q;
    ridx_d      = ridx_q;
    found_d     = found_q;
    pos_d       = pos_q;
    qty_d       = qty_q;
    rd_en       = 1'b0;
    rd_addr     = idx_q[AddrW-1:0];
    wr_en       = 1'b0;
    wr_addr     = pos_q;
    wr_data     = '{key: req_q.item_key, qty: qty_q};
    used_ext    = 32'(used_q);

    if (cfg_valid_i) begin
      reserved_d = cfg_data_i;
    end
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      kct_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          req_d    = in_item_i;
          idx_d    = '0;
          rvalid_d = 1'b0;
          found_d  = 1'b0;
          state_d  = kct_pkg::ST_SEARCH;
        end
      end
      kct_pkg::ST_SEARCH: begin
        if (rvalid_q && rd_data.key == req_q.item_key) begin
          found_d  = 1'b1;
          pos_d    = ridx_q;
          qty_d    = rd_data.qty;
          rvalid_d = 1'b0;
          state_d  = kct_pkg::ST_EXEC;
        end else if (idx_q >= used_q) begin
          rvalid_d = 1'b0;
          if (!rvalid_q) begin
            state_d = kct_pkg::ST_EXEC;
          end
        end else begin
          rd_en    = 1'b1;
          rd_addr  = idx_q[AddrW-1:0];
          ridx_d   = idx_q[AddrW-1:0];
          rvalid_d = 1'b1;
          idx_d    = UsedW'(idx_q + UsedW'(1));
        end
      end
      kct_pkg::ST_EXEC: begin
        res_d.status       = kct_pkg::STATUS_DONE;
        res_d.quantity_now = qty_seen;
        state_d            = kct_pkg::ST_DONE;
        case (kct_pkg::mode_e'(req_q.mode))
          kct_pkg::MODE_QUERY: begin
          end
          kct_pkg::MODE_ADD, kct_pkg::MODE_REMOVE: begin
            if (req_q.item_key == reserved_q || req_q.amount == 8'd0) begin
              res_d.status = kct_pkg::STATUS_BAD;
            end else if (req_q.mode == kct_pkg::MODE_ADD) begin
              if (found_q) begin
                wr_en              = 1'b1;
                wr_addr            = pos_q;
                wr_data.qty        = qty_sum;
                res_d.quantity_now = qty_sum;
              end else if (used_q >= UsedW'(TableDepth)) begin
                res_d.status = kct_pkg::STATUS_FULL;
              end else begin
                wr_en              = 1'b1;
                wr_addr            = used_q[AddrW-1:0];
                wr_data.qty        = req_q.amount;
                used_d             = UsedW'(used_q + UsedW'(1));
                res_d.quantity_now = req_q.amount;
              end
            end else begin
              if (!found_q || qty_q < req_q.amount) begin
                res_d.status = kct_pkg::STATUS_ABSENT;
              end else if (qty_q == req_q.amount) begin
                rd_en              = 1'b1;
                rd_addr            = used_last[AddrW-1:0];
                res_d.quantity_now = 8'd0;
                state_d            = kct_pkg::ST_MOVE;
              end else begin
                wr_en              = 1'b1;
                wr_addr            = pos_q;
                wr_data.qty        = qty_diff;
                res_d.quantity_now = qty_diff;
              end
            end
          end
          default: begin
            res_d.status = kct_pkg::STATUS_BAD;
          end
        endcase
        used_ext           = 32'(used_d);
        res_d.entries_used = used_ext[4:0];
      end
      kct_pkg::ST_MOVE: begin
        wr_en              = 1'b1;
        wr_addr            = pos_q;
        wr_data            = rd_data;
        used_d             = used_last;
        used_ext           = 32'(used_last);
        res_d.entries_used = used_ext[4:0];
        state_d            = kct_pkg::ST_DONE;
      end
      kct_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_item_d  = res_q;
          out_valid_d = 1'b1;
          state_d     = kct_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kct_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kct_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      reserved_q  <= 8'd0;
      used_q      <= '0;
      idx_q       <= '0;
      rvalid_q    <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      reserved_q  <= reserved_d;
      used_q      <= used_d;
      idx_q       <= idx_d;
      rvalid_q    <= rvalid_d;
      found_q     <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    res_q      <= res_d;
    out_item_q <= out_item_d;
    ridx_q     <= ridx_d;
    pos_q      <= pos_d;
    qty_q      <= qty_d;
  end

endmodule

FILE: tb/key_count_table_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for key_count_table: a directed and a random request
// stream drive the table while a built-in table predictor checks every result.
// Depends on kct_pkg and the key_count_table RTL only.
module key_count_table_test;

  localparam logic [1:0] ModeUnused = 2'd3;
  localparam int unsigned Depth = kct_pkg::TableDepthDefault;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic [7:0] cfg_data = '0;
  logic in_valid = 1'b0;
  kct_pkg::in_item_t in_item = '0;
  logic out_stall = 1'b0;
  logic cfg_ready_o;
  logic in_stall_o;
  logic out_valid_o;
  kct_pkg::out_item_t out_item_o;

  kct_pkg::in_item_t pending_requests[$];
  kct_pkg::out_item_t expected_results[$];
  int idle_pct = 33;
  int stall_pct = 33;
  int mismatch_count = 0;

  logic [7:0] model_key[Depth];
  logic [7:0] model_qty[Depth];
  int unsigned model_used = 0;
  logic [7:0] model_reserved = '0;

  key_count_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_item_o  (out_item_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 100) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  function automatic int find_key(input logic [7:0] key);
    for (int i = 0; i < model_used; i++) begin
      if (model_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic kct_pkg::out_item_t table_step(input kct_pkg::in_item_t req);
    int pos;
    kct_pkg::out_item_t res;
    res.status = kct_pkg::STATUS_DONE;
    if (req.mode == ModeUnused) begin
      res.status = kct_pkg::STATUS_BAD;
    end else if (req.mode == kct_pkg::MODE_QUERY) begin
      res.status = kct_pkg::STATUS_DONE;
    end else if (req.item_key == model_reserved || req.amount == 8'd0) begin
      res.status = kct_pkg::STATUS_BAD;
    end else if (req.mode == kct_pkg::MODE_ADD) begin
      pos = find_key(req.item_key);
      if (pos >= 0) begin
        model_qty[pos] = model_qty[pos] + req.amount;
      end else if (model_used >= Depth) begin
        res.status = kct_pkg::STATUS_FULL;
      end else begin
        model_key[model_used] = req.item_key;
        model_qty[model_used] = req.amount;
        model_used++;
      end
    end else begin
      pos = find_key(req.item_key);
      if (pos < 0 || model_qty[pos] < req.amount) begin
        res.status = kct_pkg::STATUS_ABSENT;
      end else if (model_qty[pos] == req.amount) begin
        model_key[pos] = model_key[model_used - 1];
        model_qty[pos] = model_qty[model_used - 1];
        model_used--;
      end else begin
        model_qty[pos] = model_qty[pos] - req.amount;
      end
    end
    pos = find_key(req.item_key);
    res.quantity_now = (pos >= 0) ? model_qty[pos] : 8'd0;
    res.entries_used = 5'(model_used);
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (rst_n) begin
      if (!in_valid || !in_stall_o) begin
        if (in_valid) begin
          expected_results.push_back(table_step(in_item));
        end
        if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_item <= pending_requests.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    kct_pkg::out_item_t exp_res;
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if (out_valid_o && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result arrived with nothing expected");
        end else begin
          exp_res = expected_results.pop_front();
          if (out_item_o.status !== exp_res.status) begin
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_item_o.status, exp_res.status));
          end
          if (out_item_o.quantity_now !== exp_res.quantity_now) begin
            report_mismatch($sformatf("quantity_now %0d, expected %0d",
                                      out_item_o.quantity_now, exp_res.quantity_now));
          end
          if (out_item_o.entries_used !== exp_res.entries_used) begin
            report_mismatch($sformatf("entries_used %0d, expected %0d",
                                      out_item_o.entries_used, exp_res.entries_used));
          end
        end
      end
    end
  end

  function automatic void push_request(input logic [1:0] mode, input logic [7:0] key,
                                       input logic [7:0] amount);
    kct_pkg::in_item_t req;
    req.mode = mode;
    req.item_key = key;
    req.amount = amount;
    pending_requests.push_back(req);
  endfunction

  task automatic wait_drained();
    int guard;
    guard = 0;
    while ((pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
           && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reserved(input logic [7:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    model_reserved = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_random(input int count, input int add_weight);
    logic [7:0] base;
    logic [1:0] mode;
    logic [7:0] key;
    logic [7:0] amount;
    int r;
    base = 8'($urandom_range(0, 255));
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < add_weight) mode = kct_pkg::MODE_ADD;
      else if (r < 80) mode = kct_pkg::MODE_REMOVE;
      else if (r < 95) mode = kct_pkg::MODE_QUERY;
      else mode = ModeUnused;
      r = $urandom_range(99);
      if (r < 85) key = base + 8'($urandom_range(0, 19));
      else if (r < 92) key = model_reserved;
      else key = 8'($urandom_range(0, 255));
      r = $urandom_range(99);
      if (r < 70) amount = 8'($urandom_range(1, 4));
      else if (r < 95) amount = 8'($urandom_range(0, 255));
      else amount = 8'd0;
      push_request(mode, key, amount);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;

    push_request(kct_pkg::MODE_QUERY, 8'd0, 8'd255);
    push_request(kct_pkg::MODE_ADD, 8'd0, 8'd5);
    push_request(kct_pkg::MODE_ADD, 8'd255, 8'd0);
    push_request(ModeUnused, 8'd255, 8'd255);
    push_request(kct_pkg::MODE_ADD, 8'd1, 8'd255);
    push_request(kct_pkg::MODE_ADD, 8'd1, 8'd1);
    push_request(kct_pkg::MODE_REMOVE, 8'd1, 8'd1);
    push_request(kct_pkg::MODE_REMOVE, 8'd2, 8'd1);
    for (int k = 2; k <= 16; k++) begin
      push_request(kct_pkg::MODE_ADD, 8'(k), 8'(k * 7));
    end
    push_request(kct_pkg::MODE_ADD, 8'd200, 8'd3);
    push_request(kct_pkg::MODE_REMOVE, 8'd5, 8'd35);

    write_reserved(8'd255);
    queue_random(200, 45);
    write_reserved(8'($urandom_range(1, 254)));
    idle_pct = 0;
    stall_pct = 0;
    queue_random(200, 25);
    wait_drained();
    idle_pct = 33;
    stall_pct = 33;
    write_reserved(8'd0);
    queue_random(200, 45);
    write_reserved(8'd128);
    queue_random(200, 25);
    write_reserved(8'($urandom_range(1, 254)));
    queue_random(200, 40);

    wait_drained();
    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    end
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
